### src/rlt_pkg.sv
// ----------------------------------------------------------------------------
// rlt_pkg
// Shared types and codes of the residency lifecycle tracker: event and result
// beats, phases, status codes, event modes and register indexes.
// ----------------------------------------------------------------------------
package rlt_pkg;

  typedef enum logic [2:0] {
    PhUnloaded  = 3'd0,
    PhLoadQ     = 3'd1,
    PhLoading   = 3'd2,
    PhResident  = 3'd3,
    PhUnloadQ   = 3'd4,
    PhUnloading = 3'd5,
    PhFailed    = 3'd6,
    PhInvalid   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StState = 2'd1,
    StArg   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    MdQueueLoad     = 3'd0,
    MdBeginLoad     = 3'd1,
    MdCompleteLoad  = 3'd2,
    MdFailLoad      = 3'd3,
    MdQueueUnload   = 3'd4,
    MdBeginUnload   = 3'd5,
    MdCompleteUnload = 3'd6,
    MdClearFailure  = 3'd7
  } mode_e;

  localparam logic       CfgOwnKey      = 1'b0;
  localparam logic       CfgOwnKeyValid = 1'b1;
  localparam logic [3:0] FailInternal   = 4'd15;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] rev_key;
    logic [31:0] rev_number;
    logic        rev_valid;
    logic [63:0] request_tag;
    logic        snap_valid;
    logic [31:0] snap_bytes;
    logic [3:0]  error_code;
  } evt_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  phase_out;
    logic [31:0] target_rev_out;
    logic [31:0] resident_rev_out;
    logic [63:0] active_tag_out;
    logic [3:0]  failure_out;
    logic [31:0] resident_bytes_out;
    logic        resident_flag;
  } res_t;

  // compare results that feed the event decision
  typedef struct packed {
    logic rev_valid;
    logic key_hit;
    logic rev_hit;
    logic tag_zero;
    logic tag_hit;
    logic snap_valid;
  } chk_t;

  // state update controls, applied only when status is ok
  typedef struct packed {
    status_e status;
    phase_e  phase;
    logic    tgt_load;
    logic    tgt_clr;
    logic    res_take;
    logic    res_clr;
    logic    tag_load;
    logic    tag_clr;
    logic    fail_set;
    logic    fail_clr;
    logic    bytes_load;
    logic    bytes_clr;
  } upd_t;

endpackage

### src/rlt_evt_if.sv
// ----------------------------------------------------------------------------
// rlt_evt_if
// Event channel: valid, ready and one event beat.
// ----------------------------------------------------------------------------
interface rlt_evt_if;
  logic          valid;
  logic          ready;
  rlt_pkg::evt_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/rlt_res_if.sv
// ----------------------------------------------------------------------------
// rlt_res_if
// Result channel: valid, ready and one result beat.
// ----------------------------------------------------------------------------
interface rlt_res_if;
  logic          valid;
  logic          ready;
  rlt_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/residency_lifecycle_tracker.sv
// ----------------------------------------------------------------------------
// residency_lifecycle_tracker
// Load and unload lifecycle of one keyed resource: checks each event against
// the phase and stored values and answers with a status and the new state.
//
//   channel  dir  beat                                   handshake
//   evt_i    in   mode, revision, tag, snapshot, error   valid/ready
//   res_o    out  status, phase, revisions, tag, bytes   valid/ready
//   cfg      in   own_key (0), own_key_valid (1)         cfg_we_i
//
// one event per cycle while the result register can take it; each result appears the cycle after its event
// the decision for an event is one pass of compares against the state registers
// the result register holds one beat; events stall only while it is full and
// not taken
// reset gives phase invalid and all stored values zero; a register write
// restarts the lifecycle
// ----------------------------------------------------------------------------
module residency_lifecycle_tracker #(
  parameter int KEY_BITS = 32,
  parameter int REV_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  rlt_evt_if.sink     evt_i,
  rlt_res_if.source   res_o
);

  localparam int KeyW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int RevW = (REV_BITS < 32) ? REV_BITS : 32;

  logic [KeyW-1:0] own_key_q, own_key_d;
  logic            key_valid_q, key_valid_d;
  rlt_pkg::phase_e phase_q, phase_d;
  logic [RevW-1:0] tgt_q, tgt_d;
  logic [RevW-1:0] rrev_q, rrev_d;
  logic [63:0]     tag_q, tag_d;
  logic [3:0]      fail_q, fail_d;
  logic [31:0]     bytes_q, bytes_d;
  logic            out_valid_q, out_valid_d;
  rlt_pkg::res_t   out_q, out_d;

  rlt_pkg::chk_t   chk;
  rlt_pkg::upd_t   upd;
  logic            evt_acc;
  logic            ok;

  assign evt_i.ready = !out_valid_q || res_o.ready;
  assign evt_acc     = evt_i.valid && evt_i.ready;

  assign chk.rev_valid  = evt_i.payload.rev_valid;
  assign chk.key_hit    = evt_i.payload.rev_key[KeyW-1:0] == own_key_q;
  assign chk.rev_hit    = evt_i.payload.rev_number[RevW-1:0] == tgt_q;
  assign chk.tag_zero   = evt_i.payload.request_tag == 64'd0;
  assign chk.tag_hit    = !chk.tag_zero && (evt_i.payload.request_tag == tag_q);
  assign chk.snap_valid = evt_i.payload.snap_valid;

  rlt_decide u_decide (
    .mode_i      (evt_i.payload.mode),
    .phase_i     (phase_q),
    .key_valid_i (key_valid_q),
    .chk_i       (chk),
    .upd_o       (upd)
  );

  assign ok = upd.status == rlt_pkg::StOk;

  always_comb begin
    own_key_d   = own_key_q;
    key_valid_d = key_valid_q;
    phase_d     = phase_q;
    tgt_d       = tgt_q;
    rrev_d      = rrev_q;
    tag_d       = tag_q;
    fail_d      = fail_q;
    bytes_d     = bytes_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == rlt_pkg::CfgOwnKey) begin
        own_key_d = cfg_data_i[KeyW-1:0];
      end else begin
        key_valid_d = cfg_data_i[0];
      end
      phase_d = key_valid_d ? rlt_pkg::PhUnloaded : rlt_pkg::PhInvalid;
      tgt_d   = '0;
      rrev_d  = '0;
      tag_d   = '0;
      fail_d  = '0;
      bytes_d = '0;
    end else if (evt_acc && ok) begin
      phase_d = upd.phase;
      if (upd.tgt_load) tgt_d = evt_i.payload.rev_number[RevW-1:0];
      if (upd.tgt_clr) tgt_d = '0;
      if (upd.res_take) rrev_d = tgt_q;
      if (upd.res_clr) rrev_d = '0;
      if (upd.tag_load) tag_d = evt_i.payload.request_tag;
      if (upd.tag_clr) tag_d = '0;
      if (upd.fail_set) begin
        fail_d = (evt_i.payload.error_code != 4'd0) ? evt_i.payload.error_code
                                                   : rlt_pkg::FailInternal;
      end
      if (upd.fail_clr) fail_d = '0;
      if (upd.bytes_load) bytes_d = evt_i.payload.snap_bytes;
      if (upd.bytes_clr) bytes_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_o.ready) out_valid_d = 1'b0;
    if (evt_acc) out_valid_d = 1'b1;
    out_d                    = out_q;
    if (evt_acc) begin
      out_d.status             = upd.status;
      out_d.phase_out          = phase_d;
      out_d.target_rev_out     = 32'(tgt_d);
      out_d.resident_rev_out   = 32'(rrev_d);
      out_d.active_tag_out     = tag_d;
      out_d.failure_out        = fail_d;
      out_d.resident_bytes_out = bytes_d;
      out_d.resident_flag      = phase_d == rlt_pkg::PhResident ||
                                 phase_d == rlt_pkg::PhUnloadQ ||
                                 phase_d == rlt_pkg::PhUnloading;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_key_q   <= '0;
      key_valid_q <= 1'b0;
      phase_q     <= rlt_pkg::PhInvalid;
      tgt_q       <= '0;
      rrev_q      <= '0;
      tag_q       <= '0;
      fail_q      <= '0;
      bytes_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      own_key_q   <= own_key_d;
      key_valid_q <= key_valid_d;
      phase_q     <= phase_d;
      tgt_q       <= tgt_d;
      rrev_q      <= rrev_d;
      tag_q       <= tag_d;
      fail_q      <= fail_d;
      bytes_q     <= bytes_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  a_evt_gives_res : assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_acc |=> out_valid_q)
    else $error("accepted event without result beat");

  a_phase_key : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != rlt_pkg::PhInvalid |-> key_valid_q)
    else $error("live phase with invalid key");

  a_reject_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_acc && !ok && !cfg_we_i |=> $stable(phase_q) && $stable(tag_q) && $stable(tgt_q))
    else $error("rejected event changed state");

  a_tag_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_q != 64'd0 |-> phase_q == rlt_pkg::PhLoadQ || phase_q == rlt_pkg::PhLoading)
    else $error("active tag outside a pending load");

endmodule

### src/rlt_decide.sv
// ----------------------------------------------------------------------------
// rlt_decide
// Event decision: checks one event against the phase and the compare results
// and gives the status, the next phase and the state update controls.
// ----------------------------------------------------------------------------
module rlt_decide (
  input  logic [2:0]      mode_i,
  input  rlt_pkg::phase_e phase_i,
  input  logic            key_valid_i,
  input  rlt_pkg::chk_t   chk_i,
  output rlt_pkg::upd_t   upd_o
);

  always_comb begin
    upd_o = '0;
    upd_o.status = rlt_pkg::StOk;
    upd_o.phase  = phase_i;
    if (!key_valid_i || phase_i == rlt_pkg::PhInvalid) begin
      upd_o.status = rlt_pkg::StState;
    end else begin
      unique case (rlt_pkg::mode_e'(mode_i))
        rlt_pkg::MdQueueLoad: begin
          priority if (phase_i != rlt_pkg::PhUnloaded) begin
            upd_o.status = rlt_pkg::StState;
          end else if (!chk_i.rev_valid || !chk_i.key_hit || chk_i.tag_zero) begin
            upd_o.status = rlt_pkg::StArg;
          end else begin
            upd_o.phase     = rlt_pkg::PhLoadQ;
            upd_o.tgt_load  = 1'b1;
            upd_o.res_clr   = 1'b1;
            upd_o.tag_load  = 1'b1;
            upd_o.fail_clr  = 1'b1;
            upd_o.bytes_clr = 1'b1;
          end
        end
        rlt_pkg::MdBeginLoad: begin
          priority if (phase_i != rlt_pkg::PhLoadQ) begin
            upd_o.status = rlt_pkg::StState;
          end else if (!chk_i.tag_hit) begin
            upd_o.status = rlt_pkg::StArg;
          end else begin
            upd_o.phase = rlt_pkg::PhLoading;
          end
        end
        rlt_pkg::MdCompleteLoad: begin
          priority if (phase_i != rlt_pkg::PhLoading) begin
            upd_o.status = rlt_pkg::StState;
          end else if (!chk_i.tag_hit || !chk_i.snap_valid ||
                       !chk_i.key_hit || !chk_i.rev_hit) begin
            upd_o.status = rlt_pkg::StArg;
          end else begin
            upd_o.phase      = rlt_pkg::PhResident;
            upd_o.res_take   = 1'b1;
            upd_o.bytes_load = 1'b1;
            upd_o.tgt_clr    = 1'b1;
            upd_o.tag_clr    = 1'b1;
            upd_o.fail_clr   = 1'b1;
          end
        end
        rlt_pkg::MdFailLoad: begin
          priority if (phase_i != rlt_pkg::PhLoadQ && phase_i != rlt_pkg::PhLoading) begin
            upd_o.status = rlt_pkg::StState;
          end else if (!chk_i.tag_hit) begin
            upd_o.status = rlt_pkg::StArg;
          end else begin
            upd_o.phase     = rlt_pkg::PhFailed;
            upd_o.res_clr   = 1'b1;
            upd_o.tag_clr   = 1'b1;
            upd_o.bytes_clr = 1'b1;
            upd_o.fail_set  = 1'b1;
          end
        end
        rlt_pkg::MdQueueUnload: begin
          if (phase_i != rlt_pkg::PhResident) begin
            upd_o.status = rlt_pkg::StState;
          end else begin
            upd_o.phase = rlt_pkg::PhUnloadQ;
          end
        end
        rlt_pkg::MdBeginUnload: begin
          if (phase_i != rlt_pkg::PhUnloadQ) begin
            upd_o.status = rlt_pkg::StState;
          end else begin
            upd_o.phase = rlt_pkg::PhUnloading;
          end
        end
        rlt_pkg::MdCompleteUnload, rlt_pkg::MdClearFailure: begin
          if ((mode_i == rlt_pkg::MdCompleteUnload && phase_i != rlt_pkg::PhUnloading) ||
              (mode_i == rlt_pkg::MdClearFailure && phase_i != rlt_pkg::PhFailed)) begin
            upd_o.status = rlt_pkg::StState;
          end else begin
            upd_o.phase     = rlt_pkg::PhUnloaded;
            upd_o.tgt_clr   = 1'b1;
            upd_o.res_clr   = 1'b1;
            upd_o.tag_clr   = 1'b1;
            upd_o.fail_clr  = 1'b1;
            upd_o.bytes_clr = 1'b1;
          end
        end
        default: begin
          upd_o.status = rlt_pkg::StState;
        end
      endcase
    end
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for residency_lifecycle_tracker. Events go in on the event
// channel, and the expected answer of each accepted event is queued. Each
// result beat is compared with the oldest queued answer, field by field. The
// run sends every mode with no key set, then has a directed pass over the
// lifecycle and its argument checks, a backpressure phase and random lifecycles
// under several keys. The sender pauses in random bursts, the receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned HoldCycles = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_data_i;

  rlt_evt_if evt_if ();
  rlt_res_if res_if ();

  residency_lifecycle_tracker u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .evt_i      (evt_if),
    .res_o      (res_if)
  );

  always #4 clk_i = ~clk_i;

  // tracker state as the block should hold it
  logic [31:0]     trk_key = '0;
  logic            trk_key_ok = 1'b0;
  rlt_pkg::phase_e trk_phase = rlt_pkg::PhInvalid;
  logic [31:0]     trk_tgt = '0;
  logic [31:0]     trk_res_rev = '0;
  logic [63:0]     trk_tag = '0;
  logic [3:0]      trk_fail = '0;
  logic [31:0]     trk_bytes = '0;

  rlt_pkg::res_t pending_res_q[$];
  int unsigned   err_cnt = 0;

  // stimulus side: phase the random sequence is aiming at
  rlt_pkg::phase_e gen_ph = rlt_pkg::PhInvalid;
  logic [63:0]     gen_tag;
  logic [31:0]     gen_rev;

  int unsigned burst_left = 0;
  bit          no_gaps = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned rx_left = 0;
  int unsigned rx_mode = 0;
  logic [7:0]  rx_cnt = '0;
  int unsigned idle_cycles = 0;

  function automatic void restart_lifecycle();
    trk_phase   = trk_key_ok ? rlt_pkg::PhUnloaded : rlt_pkg::PhInvalid;
    trk_tgt     = '0;
    trk_res_rev = '0;
    trk_tag     = '0;
    trk_fail    = '0;
    trk_bytes   = '0;
  endfunction

  function automatic rlt_pkg::res_t lifecycle_step(rlt_pkg::evt_t e);
    rlt_pkg::res_t    r;
    rlt_pkg::status_e st;
    rlt_pkg::phase_e  ph;
    logic             tag_ok;
    st = rlt_pkg::StOk;
    tag_ok = e.request_tag != '0 && e.request_tag == trk_tag;
    if (!trk_key_ok || trk_phase == rlt_pkg::PhInvalid) begin
      st = rlt_pkg::StState;
    end else begin
      case (rlt_pkg::mode_e'(e.mode))
        rlt_pkg::MdQueueLoad: begin
          if (trk_phase != rlt_pkg::PhUnloaded) st = rlt_pkg::StState;
          else if (!e.rev_valid || e.rev_key != trk_key || e.request_tag == '0)
            st = rlt_pkg::StArg;
          else begin
            trk_tgt     = e.rev_number;
            trk_res_rev = '0;
            trk_tag     = e.request_tag;
            trk_fail    = '0;
            trk_bytes   = '0;
            trk_phase   = rlt_pkg::PhLoadQ;
          end
        end
        rlt_pkg::MdBeginLoad: begin
          if (trk_phase != rlt_pkg::PhLoadQ) st = rlt_pkg::StState;
          else if (!tag_ok) st = rlt_pkg::StArg;
          else trk_phase = rlt_pkg::PhLoading;
        end
        rlt_pkg::MdCompleteLoad: begin
          if (trk_phase != rlt_pkg::PhLoading) st = rlt_pkg::StState;
          else if (!tag_ok || !e.snap_valid) st = rlt_pkg::StArg;
          else if (e.rev_key != trk_key || e.rev_number != trk_tgt) st = rlt_pkg::StArg;
          else begin
            trk_res_rev = trk_tgt;
            trk_bytes   = e.snap_bytes;
            trk_tgt     = '0;
            trk_tag     = '0;
            trk_fail    = '0;
            trk_phase   = rlt_pkg::PhResident;
          end
        end
        rlt_pkg::MdFailLoad: begin
          if (trk_phase != rlt_pkg::PhLoadQ && trk_phase != rlt_pkg::PhLoading)
            st = rlt_pkg::StState;
          else if (!tag_ok) st = rlt_pkg::StArg;
          else begin
            trk_res_rev = '0;
            trk_tag     = '0;
            trk_bytes   = '0;
            trk_fail    = (e.error_code != '0) ? e.error_code : rlt_pkg::FailInternal;
            trk_phase   = rlt_pkg::PhFailed;
          end
        end
        rlt_pkg::MdQueueUnload: begin
          if (trk_phase != rlt_pkg::PhResident) st = rlt_pkg::StState;
          else trk_phase = rlt_pkg::PhUnloadQ;
        end
        rlt_pkg::MdBeginUnload: begin
          if (trk_phase != rlt_pkg::PhUnloadQ) st = rlt_pkg::StState;
          else trk_phase = rlt_pkg::PhUnloading;
        end
        rlt_pkg::MdCompleteUnload: begin
          if (trk_phase != rlt_pkg::PhUnloading) st = rlt_pkg::StState;
          else restart_lifecycle();
        end
        default: begin
          if (trk_phase != rlt_pkg::PhFailed) st = rlt_pkg::StState;
          else restart_lifecycle();
        end
      endcase
    end
    ph = trk_key_ok ? trk_phase : rlt_pkg::PhInvalid;
    r.status             = st;
    r.phase_out          = ph;
    r.target_rev_out     = trk_tgt;
    r.resident_rev_out   = trk_res_rev;
    r.active_tag_out     = trk_tag;
    r.failure_out        = trk_fail;
    r.resident_bytes_out = trk_bytes;
    r.resident_flag      = ph == rlt_pkg::PhResident || ph == rlt_pkg::PhUnloadQ ||
                           ph == rlt_pkg::PhUnloading;
    return r;
  endfunction

  task automatic report_err(input string msg);
    if (err_cnt < 40) $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_err($sformatf("%s got %h want %h", name, got, want));
  endtask

  // result check first, then prediction of the event beat taken at this edge
  always @(posedge clk_i) begin : scoreboard
    rlt_pkg::res_t want;
    rlt_pkg::res_t got;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got = res_if.payload;
        if (pending_res_q.size() == 0) begin
          report_err("result beat with nothing pending");
        end else begin
          want = pending_res_q.pop_front();
          check_field("status", 64'(got.status), 64'(want.status));
          check_field("phase_out", 64'(got.phase_out), 64'(want.phase_out));
          check_field("target_rev_out", 64'(got.target_rev_out),
                      64'(want.target_rev_out));
          check_field("resident_rev_out", 64'(got.resident_rev_out),
                      64'(want.resident_rev_out));
          check_field("active_tag_out", got.active_tag_out, want.active_tag_out);
          check_field("failure_out", 64'(got.failure_out), 64'(want.failure_out));
          check_field("resident_bytes_out", 64'(got.resident_bytes_out),
                      64'(want.resident_bytes_out));
          check_field("resident_flag", 64'(got.resident_flag), 64'(want.resident_flag));
        end
      end
      if (evt_if.valid && evt_if.ready) pending_res_q.push_back(lifecycle_step(evt_if.payload));
    end
  end

  // receiver stall pattern, with one long hold on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
      res_if.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_left = $urandom_range(8, 64);
        rx_mode = $urandom_range(0, 3);
      end
      rx_left--;
      rx_cnt++;
      case (rx_mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= 1'($urandom_range(0, 1));
        2: res_if.ready <= (rx_cnt[1:0] == 2'd0);
        default: res_if.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("residency_lifecycle_tracker test failed");
      $finish;
    end
  end

  task automatic send_evt(input rlt_pkg::evt_t e);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        evt_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    evt_if.valid   <= 1'b1;
    evt_if.payload <= e;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    evt_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic idx, input logic [31:0] data);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rlt_pkg::CfgOwnKey) trk_key = data;
    else trk_key_ok = data[0];
    restart_lifecycle();
    gen_ph = trk_phase;
    @(posedge clk_i);
  endtask

  function automatic rlt_pkg::evt_t make_evt(rlt_pkg::mode_e m, logic [31:0] key,
                                             logic [31:0] rev, logic rv,
                                             logic [63:0] tag, logic sv,
                                             logic [31:0] bytes, logic [3:0] err);
    rlt_pkg::evt_t e;
    e.mode        = m;
    e.rev_key     = key;
    e.rev_number  = rev;
    e.rev_valid   = rv;
    e.request_tag = tag;
    e.snap_valid  = sv;
    e.snap_bytes  = bytes;
    e.error_code  = err;
    return e;
  endfunction

  function automatic bit mode_fits(rlt_pkg::phase_e ph, rlt_pkg::mode_e m);
    bit ok;
    case (m)
      rlt_pkg::MdQueueLoad:      ok = ph == rlt_pkg::PhUnloaded;
      rlt_pkg::MdBeginLoad:      ok = ph == rlt_pkg::PhLoadQ;
      rlt_pkg::MdCompleteLoad:   ok = ph == rlt_pkg::PhLoading;
      rlt_pkg::MdFailLoad:       ok = ph == rlt_pkg::PhLoadQ || ph == rlt_pkg::PhLoading;
      rlt_pkg::MdQueueUnload:    ok = ph == rlt_pkg::PhResident;
      rlt_pkg::MdBeginUnload:    ok = ph == rlt_pkg::PhUnloadQ;
      rlt_pkg::MdCompleteUnload: ok = ph == rlt_pkg::PhUnloading;
      default:                   ok = ph == rlt_pkg::PhFailed;
    endcase
    return ok;
  endfunction

  // mostly the next legal step of a lifecycle, else a beat that must be rejected
  function automatic rlt_pkg::evt_t next_evt();
    rlt_pkg::evt_t e;
    logic [31:0]   nz;
    e.mode        = 3'($urandom_range(0, 7));
    e.rev_key     = $urandom;
    e.rev_number  = $urandom;
    e.rev_valid   = 1'($urandom_range(0, 1));
    e.request_tag = {$urandom, $urandom};
    e.snap_valid  = 1'($urandom_range(0, 1));
    e.snap_bytes  = $urandom;
    e.error_code  = 4'($urandom_range(0, 15));
    nz = $urandom;
    if (nz == '0) nz = 32'd1;
    if ($urandom_range(0, 99) < 80) begin
      case (gen_ph)
        rlt_pkg::PhUnloaded: begin
          e.mode      = rlt_pkg::MdQueueLoad;
          e.rev_valid = 1'b1;
          e.rev_key   = trk_key;
          if (e.request_tag == '0) e.request_tag = 64'd1;
          gen_tag = e.request_tag;
          gen_rev = e.rev_number;
          gen_ph  = rlt_pkg::PhLoadQ;
        end
        rlt_pkg::PhLoadQ: begin
          e.request_tag = gen_tag;
          if ($urandom_range(0, 3) != 0) begin
            e.mode = rlt_pkg::MdBeginLoad;
            gen_ph = rlt_pkg::PhLoading;
          end else begin
            e.mode = rlt_pkg::MdFailLoad;
            gen_ph = rlt_pkg::PhFailed;
          end
        end
        rlt_pkg::PhLoading: begin
          e.request_tag = gen_tag;
          if ($urandom_range(0, 3) != 0) begin
            e.mode       = rlt_pkg::MdCompleteLoad;
            e.snap_valid = 1'b1;
            e.rev_key    = trk_key;
            e.rev_number = gen_rev;
            gen_ph = rlt_pkg::PhResident;
          end else begin
            e.mode = rlt_pkg::MdFailLoad;
            gen_ph = rlt_pkg::PhFailed;
          end
        end
        rlt_pkg::PhResident: begin
          e.mode = rlt_pkg::MdQueueUnload;
          gen_ph = rlt_pkg::PhUnloadQ;
        end
        rlt_pkg::PhUnloadQ: begin
          e.mode = rlt_pkg::MdBeginUnload;
          gen_ph = rlt_pkg::PhUnloading;
        end
        rlt_pkg::PhUnloading: begin
          e.mode = rlt_pkg::MdCompleteUnload;
          gen_ph = rlt_pkg::PhUnloaded;
        end
        rlt_pkg::PhFailed: begin
          e.mode = rlt_pkg::MdClearFailure;
          gen_ph = rlt_pkg::PhUnloaded;
        end
        default: ;
      endcase
    end else if (mode_fits(gen_ph, rlt_pkg::mode_e'(e.mode))) begin
      case (rlt_pkg::mode_e'(e.mode))
        rlt_pkg::MdQueueLoad: begin
          case ($urandom_range(0, 2))
            0: e.rev_valid = 1'b0;
            1: e.rev_key = trk_key ^ nz;
            default: e.request_tag = '0;
          endcase
        end
        rlt_pkg::MdBeginLoad, rlt_pkg::MdFailLoad: begin
          e.request_tag = $urandom_range(0, 1) ? 64'd0 : gen_tag ^ {$urandom, nz};
        end
        rlt_pkg::MdCompleteLoad: begin
          e.request_tag = gen_tag;
          e.snap_valid  = 1'b1;
          e.rev_key     = trk_key;
          e.rev_number  = gen_rev;
          case ($urandom_range(0, 3))
            0: e.request_tag = gen_tag ^ {$urandom, nz};
            1: e.snap_valid = 1'b0;
            2: e.rev_key = trk_key ^ nz;
            default: e.rev_number = gen_rev ^ nz;
          endcase
        end
        default: e.mode = rlt_pkg::MdQueueLoad;
      endcase
    end
    return e;
  endfunction

  task automatic run_random(input int unsigned n);
    repeat (n) send_evt(next_evt());
  endtask

  task automatic test_reset_state();
    for (int m = 0; m < 8; m++) begin
      send_evt(make_evt(rlt_pkg::mode_e'(m), $urandom, $urandom, 1'b1, {$urandom, $urandom},
                        1'b1, $urandom, 4'($urandom_range(0, 15))));
    end
  endtask

  task automatic test_directed();
    logic [31:0] k;
    logic [63:0] t;
    logic [63:0] h;
    k = 32'hFFFF_FFFF;
    t = 64'hFFFF_FFFF_FFFF_FFFF;
    h = 64'h8000_0000_0000_0000;
    set_reg(rlt_pkg::CfgOwnKey, k);
    set_reg(rlt_pkg::CfgOwnKeyValid, 32'd1);
    // queue load argument checks and wrong phase
    send_evt(make_evt(rlt_pkg::MdQueueLoad, k, '0, 1'b0, t, 1'b1, '0, '0));
    send_evt(make_evt(rlt_pkg::MdQueueLoad, '0, '0, 1'b1, t, 1'b1, '0, '0));
    send_evt(make_evt(rlt_pkg::MdQueueLoad, k, '0, 1'b1, '0, 1'b1, '0, '0));
    send_evt(make_evt(rlt_pkg::MdBeginLoad, k, '0, 1'b1, t, 1'b1, '0, '0));
    send_evt(make_evt(rlt_pkg::MdQueueLoad, k, '0, 1'b1, t, 1'b0, '0, '0));
    // tag mismatch
    send_evt(make_evt(rlt_pkg::MdBeginLoad, k, '0, 1'b1, '0, 1'b1, '0, '0));
    send_evt(make_evt(rlt_pkg::MdBeginLoad, k, '0, 1'b1, 64'd1, 1'b1, '0, '0));
    send_evt(make_evt(rlt_pkg::MdBeginLoad, '0, 32'hFFFF_FFFF, 1'b0, t, 1'b0, '0, '0));
    // complete load: snapshot, key and revision mismatch, then a good completion
    send_evt(make_evt(rlt_pkg::MdCompleteLoad, k, '0, 1'b1, t, 1'b0, 32'hFFFF_FFFF, '0));
    send_evt(make_evt(rlt_pkg::MdCompleteLoad, 32'h7FFF_FFFF, '0, 1'b1, t, 1'b1,
                      32'hFFFF_FFFF, '0));
    send_evt(make_evt(rlt_pkg::MdCompleteLoad, k, 32'd1, 1'b1, t, 1'b1, 32'hFFFF_FFFF, '0));
    send_evt(make_evt(rlt_pkg::MdCompleteLoad, k, '0, 1'b0, t, 1'b1, 32'hFFFF_FFFF, 4'hF));
    // unload path
    send_evt(make_evt(rlt_pkg::MdQueueLoad, k, '0, 1'b1, t, 1'b1, '0, '0));
    send_evt(make_evt(rlt_pkg::MdQueueUnload, '0, '0, 1'b0, '0, 1'b0, '0, '0));
    send_evt(make_evt(rlt_pkg::MdClearFailure, '0, '0, 1'b0, '0, 1'b0, '0, '0));
    send_evt(make_evt(rlt_pkg::MdBeginUnload, '0, '0, 1'b0, '0, 1'b0, '0, '0));
    send_evt(make_evt(rlt_pkg::MdCompleteUnload, '0, '0, 1'b0, '0, 1'b0, '0, '0));
    // fail load with no code given, then with one, from both load phases
    send_evt(make_evt(rlt_pkg::MdQueueLoad, k, 32'hFFFF_FFFF, 1'b1, 64'd1, 1'b0, '0, '0));
    send_evt(make_evt(rlt_pkg::MdFailLoad, '0, '0, 1'b0, 64'd2, 1'b0, '0, '0));
    send_evt(make_evt(rlt_pkg::MdFailLoad, '0, '0, 1'b0, 64'd1, 1'b0, '0, '0));
    send_evt(make_evt(rlt_pkg::MdClearFailure, '0, '0, 1'b0, '0, 1'b0, '0, '0));
    send_evt(make_evt(rlt_pkg::MdQueueLoad, k, 32'd5, 1'b1, h, 1'b0, '0, '0));
    send_evt(make_evt(rlt_pkg::MdBeginLoad, '0, '0, 1'b0, h, 1'b0, '0, '0));
    send_evt(make_evt(rlt_pkg::MdFailLoad, '0, '0, 1'b0, h, 1'b0, '0, 4'h7));
    send_evt(make_evt(rlt_pkg::MdClearFailure, '0, '0, 1'b0, '0, 1'b0, '0, '0));
    // key not valid
    set_reg(rlt_pkg::CfgOwnKeyValid, 32'd0);
    send_evt(make_evt(rlt_pkg::MdQueueLoad, k, '0, 1'b1, t, 1'b1, '0, '0));
  endtask

  task automatic test_backpressure();
    set_reg(rlt_pkg::CfgOwnKey, $urandom);
    set_reg(rlt_pkg::CfgOwnKeyValid, 32'd1);
    hold_req = 1'b1;
    no_gaps = 1'b1;
    run_random(40);
    no_gaps = 1'b0;
  endtask

  task automatic test_random();
    logic [31:0] keys [4];
    keys = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
    foreach (keys[i]) begin
      set_reg(rlt_pkg::CfgOwnKey, keys[i]);
      set_reg(rlt_pkg::CfgOwnKeyValid, 32'd1);
      run_random(180);
    end
    set_reg(rlt_pkg::CfgOwnKeyValid, 32'd0);
    run_random(40);
    set_reg(rlt_pkg::CfgOwnKeyValid, 32'd1);
    run_random(100);
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= 1'b0;
    cfg_data_i     <= '0;
    evt_if.valid   <= 1'b0;
    evt_if.payload <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed();
    test_backpressure();
    test_random();
    wait_idle();
    if (err_cnt == 0) begin
      $display("residency_lifecycle_tracker test passed");
    end else begin
      $display("residency_lifecycle_tracker test failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/rlt_pkg.sv
src/rlt_evt_if.sv
src/rlt_res_if.sv
src/rlt_decide.sv
src/residency_lifecycle_tracker.sv
tb/tb_top.sv
